// ===== rtl/core/mfld_pkg.sv =====
// ----------------------------------------------------------------------------
// mfld_pkg: shared types and constants of the framebuffer drawer
// Function codes, command kinds, engine states and the queued command word.
// ----------------------------------------------------------------------------
package mfld_pkg;

  localparam int DEF_WIDTH   = 128;
  localparam int DEF_HEIGHT  = 64;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_LINE  = 3'd2;
  localparam logic [2:0] FUNC_ARC   = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  typedef enum logic [2:0] {
    K_CLEAR, K_PIXEL, K_LINE, K_ARC, K_READ, K_NOP
  } kind_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_LINE_CHK, S_LINE_STEP, S_ARC_ANCH, S_ARC_CHK,
    S_ARC_PT, S_PLOT_RD, S_PLOT_WR, S_READ_RD, S_READ_CAP, S_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        x_a;
    logic [7:0]        y_a;
    logic [7:0]        x_b;
    logic [7:0]        y_b;
    logic [7:0]        radius;
    logic              color;
    logic [ADDR_W-1:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic valid;
  } q_ctl_t;

endpackage

// ===== rtl/core/mfld_if.sv =====
// ----------------------------------------------------------------------------
// mfld channel interfaces
// Command word channel and response word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfld_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x_a;
  logic [7:0] y_a;
  logic [7:0] x_b;
  logic [7:0] y_b;
  logic [7:0] radius;
  logic       color;
  logic [9:0] read_address;

  modport source (output valid, func, x_a, y_a, x_b, y_b, radius, color, read_address,
                  input ready);
  modport sink (input valid, func, x_a, y_a, x_b, y_b, radius, color, read_address,
                output ready);
endinterface

interface mfld_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/core/mfld_front.sv =====
// ----------------------------------------------------------------------------
// mfld_front: command intake
// Decodes func into a command kind and holds words in a two-entry queue.
// ----------------------------------------------------------------------------
module mfld_front (
  input  logic              clk,
  input  logic              rst,
  mfld_cmd_if.sink          cmd,
  input  logic              pop,
  output logic              q_valid,
  output mfld_pkg::cmd_t    q_cmd
);

  mfld_pkg::cmd_t q [mfld_pkg::QUEUE_DEPTH];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push;
  mfld_pkg::cmd_t word;

  always_comb begin
    word.x_a          = cmd.x_a;
    word.y_a          = cmd.y_a;
    word.x_b          = cmd.x_b;
    word.y_b          = cmd.y_b;
    word.radius       = cmd.radius;
    word.color        = cmd.color;
    word.read_address = cmd.read_address;
    unique case (cmd.func)
      mfld_pkg::FUNC_CLEAR: word.kind = mfld_pkg::K_CLEAR;
      mfld_pkg::FUNC_PIXEL: word.kind = mfld_pkg::K_PIXEL;
      mfld_pkg::FUNC_LINE:  word.kind = mfld_pkg::K_LINE;
      mfld_pkg::FUNC_ARC:   word.kind = mfld_pkg::K_ARC;
      mfld_pkg::FUNC_READ:  word.kind = mfld_pkg::K_READ;
      default:              word.kind = mfld_pkg::K_NOP;
    endcase
  end

  assign cmd.ready = (count != 2'(mfld_pkg::QUEUE_DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/mfld_back.sv =====
// ----------------------------------------------------------------------------
// mfld_back: drawing engine
// Frame store, clear sweep, line and arc walkers, one read-modify-write per pixel.
// ----------------------------------------------------------------------------
module mfld_back #(
  parameter int WIDTH  = mfld_pkg::DEF_WIDTH,
  parameter int HEIGHT = mfld_pkg::DEF_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  mfld_pkg::q_ctl_t    qin,
  input  mfld_pkg::cmd_t      q_cmd,
  output logic                pop,
  mfld_rsp_if.source          rsp
);

  localparam int AW = mfld_pkg::ADDR_W;

  mfld_pkg::state_t state, state_next, ret;
  mfld_pkg::cmd_t   c;

  logic [7:0]  mem [mfld_pkg::STORE_DEPTH];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic [AW:0] sweep;
  logic [7:0]  pt_x, pt_y;
  logic [7:0]  result;
  logic        o_valid;
  logic [7:0]  o_data;

  // line walker
  logic [7:0] ax, ay, bx, by, dx, dy;
  logic       stx, sty;
  logic signed [9:0]  err;
  logic signed [10:0] twice, dx_s, ndy_s;
  logic               step_x, step_y;

  // arc walker
  logic [7:0] wx, wy;
  logic [1:0] sub;
  logic signed [10:0] incx, incy, incy_n;
  logic signed [11:0] dec, dec_n;
  logic               dec_ge;

  // plot address
  logic        in_bounds;
  logic [14:0] idx;
  logic [7:0]  bitm;

  assign idx       = 15'(pt_x) + 15'(pt_y[7:3]) * 15'(WIDTH);
  assign in_bounds = ({1'b0, pt_x} < 9'(WIDTH)) && ({1'b0, pt_y} < 9'(HEIGHT))
                     && (idx < 15'(mfld_pkg::STORE_DEPTH));
  assign bitm      = 8'd1 << pt_y[2:0];

  assign dx_s   = 11'(signed'({1'b0, dx}));
  assign ndy_s  = -11'(signed'({1'b0, dy}));
  assign twice  = 11'(err) <<< 1;
  assign step_x = twice > ndy_s;
  assign step_y = twice < dx_s;

  assign dec_ge = !dec[11];
  assign incy_n = dec_ge ? incy + 11'sd2 : incy;
  assign dec_n  = dec + (dec_ge ? 12'(incy_n) : 12'sd0) + 12'(incx + 11'sd2);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mfld_pkg::S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx[AW-1:0];
    mem_wd     = c.color ? (mem_q | bitm) : (mem_q & ~bitm);
    mem_ra     = idx[AW-1:0];
    unique case (state)
      mfld_pkg::S_INIT, mfld_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sweep[AW-1:0];
        mem_wd = '0;
        if (sweep[AW-1:0] == AW'(mfld_pkg::STORE_DEPTH - 1)) begin
          state_next = (state == mfld_pkg::S_INIT) ? mfld_pkg::S_IDLE : mfld_pkg::S_DONE;
        end
      end
      mfld_pkg::S_IDLE: begin
        if (qin.valid) begin
          pop = 1'b1;
          unique case (q_cmd.kind)
            mfld_pkg::K_CLEAR: state_next = mfld_pkg::S_CLEAR;
            mfld_pkg::K_PIXEL: state_next = mfld_pkg::S_PLOT_RD;
            mfld_pkg::K_LINE:  state_next = mfld_pkg::S_PLOT_RD;
            mfld_pkg::K_ARC:   state_next = mfld_pkg::S_ARC_ANCH;
            mfld_pkg::K_READ:  state_next = mfld_pkg::S_READ_RD;
            default:           state_next = mfld_pkg::S_DONE;
          endcase
        end
      end
      mfld_pkg::S_LINE_CHK: begin
        state_next = (ax == bx && ay == by) ? mfld_pkg::S_DONE : mfld_pkg::S_PLOT_RD;
      end
      mfld_pkg::S_LINE_STEP: state_next = mfld_pkg::S_LINE_CHK;
      mfld_pkg::S_ARC_ANCH:  state_next = mfld_pkg::S_PLOT_RD;
      mfld_pkg::S_ARC_CHK:   state_next = (wx < wy) ? mfld_pkg::S_ARC_PT : mfld_pkg::S_DONE;
      mfld_pkg::S_ARC_PT:    state_next = mfld_pkg::S_PLOT_RD;
      mfld_pkg::S_PLOT_RD:   state_next = mfld_pkg::S_PLOT_WR;
      mfld_pkg::S_PLOT_WR: begin
        mem_we     = in_bounds;
        state_next = ret;
      end
      mfld_pkg::S_READ_RD: begin
        mem_ra     = c.read_address;
        state_next = mfld_pkg::S_READ_CAP;
      end
      mfld_pkg::S_READ_CAP: state_next = mfld_pkg::S_DONE;
      mfld_pkg::S_DONE: begin
        if (!o_valid || rsp.ready) state_next = mfld_pkg::S_IDLE;
      end
      default: state_next = mfld_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mfld_pkg::S_INIT, mfld_pkg::S_CLEAR: sweep <= sweep + 1'b1;
      mfld_pkg::S_IDLE: begin
        c      <= q_cmd;
        result <= '0;
        sweep  <= '0;
        // pixel, or line end point first
        pt_x   <= (q_cmd.kind == mfld_pkg::K_LINE) ? q_cmd.x_b : q_cmd.x_a;
        pt_y   <= (q_cmd.kind == mfld_pkg::K_LINE) ? q_cmd.y_b : q_cmd.y_a;
        ret    <= (q_cmd.kind == mfld_pkg::K_LINE) ? mfld_pkg::S_LINE_CHK : mfld_pkg::S_DONE;
        ax     <= q_cmd.x_a;
        ay     <= q_cmd.y_a;
        bx     <= q_cmd.x_b;
        by     <= q_cmd.y_b;
        dx     <= (q_cmd.x_b > q_cmd.x_a) ? q_cmd.x_b - q_cmd.x_a : q_cmd.x_a - q_cmd.x_b;
        dy     <= (q_cmd.y_b > q_cmd.y_a) ? q_cmd.y_b - q_cmd.y_a : q_cmd.y_a - q_cmd.y_b;
        stx    <= q_cmd.x_a < q_cmd.x_b;
        sty    <= q_cmd.y_a < q_cmd.y_b;
        err    <= 10'(signed'({1'b0, (q_cmd.x_b > q_cmd.x_a) ? q_cmd.x_b - q_cmd.x_a
                                              : q_cmd.x_a - q_cmd.x_b}))
                - 10'(signed'({1'b0, (q_cmd.y_b > q_cmd.y_a) ? q_cmd.y_b - q_cmd.y_a
                                              : q_cmd.y_a - q_cmd.y_b}));
        wx     <= '0;
        wy     <= q_cmd.radius;
        sub    <= '0;
        incx   <= 11'sd1;
        incy   <= -11'(signed'({2'b0, q_cmd.radius, 1'b0}));
        dec    <= 12'sd1 - 12'(signed'({1'b0, q_cmd.radius}));
      end
      mfld_pkg::S_LINE_CHK: begin
        pt_x <= ax;
        pt_y <= ay;
        ret  <= mfld_pkg::S_LINE_STEP;
      end
      mfld_pkg::S_LINE_STEP: begin
        if (step_x) ax <= stx ? ax + 8'd1 : ax - 8'd1;
        if (step_y) ay <= sty ? ay + 8'd1 : ay - 8'd1;
        err <= err - (step_x ? 10'(signed'({1'b0, dy})) : 10'sd0)
                   + (step_y ? 10'(signed'({1'b0, dx})) : 10'sd0);
      end
      mfld_pkg::S_ARC_ANCH: begin
        case (sub)
          2'd0:    begin pt_x <= c.x_a + c.radius; pt_y <= c.y_a; end
          2'd1:    begin pt_x <= c.x_a - c.radius; pt_y <= c.y_a; end
          default: begin pt_x <= c.x_a; pt_y <= c.y_a - c.radius; end
        endcase
        ret <= (sub == 2'd2) ? mfld_pkg::S_ARC_CHK : mfld_pkg::S_ARC_ANCH;
        sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
      end
      mfld_pkg::S_ARC_CHK: begin
        if (wx < wy) begin
          if (dec_ge) wy <= wy - 8'd1;
          incy <= incy_n;
          incx <= incx + 11'sd2;
          dec  <= dec_n;
          wx   <= wx + 8'd1;
          sub  <= '0;
        end
      end
      mfld_pkg::S_ARC_PT: begin
        case (sub)
          2'd0:    begin pt_x <= c.x_a + wx; pt_y <= c.y_a - wy; end
          2'd1:    begin pt_x <= c.x_a + wy; pt_y <= c.y_a - wx; end
          2'd2:    begin pt_x <= c.x_a - wx; pt_y <= c.y_a - wy; end
          default: begin pt_x <= c.x_a - wy; pt_y <= c.y_a - wx; end
        endcase
        ret <= (sub == 2'd3) ? mfld_pkg::S_ARC_CHK : mfld_pkg::S_ARC_PT;
        sub <= sub + 2'd1;
      end
      mfld_pkg::S_READ_CAP: result <= mem_q;
      default: ;
    endcase
    if (rst) sweep <= '0;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == mfld_pkg::S_DONE && (!o_valid || rsp.ready)) begin
      o_valid <= 1'b1;
      o_data  <= result;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_data;

endmodule

// ===== rtl/core/mono_framebuffer_line_arc_drawer.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_line_arc_drawer: monochrome page framebuffer drawing engine
// Clear, pixel, line, semicircle and byte readback over a 1024-byte store.
// ----------------------------------------------------------------------------
// The engine runs one command at a time; each pixel costs one
//   read-modify-write on the frame store, which has one read and one write port.
// Reset: control state clears at once, then the store is swept to zero,
//   one byte a cycle over all 1024 bytes; commands queue but are not run meanwhile.
module mono_framebuffer_line_arc_drawer #(
  parameter int WIDTH  = mfld_pkg::DEF_WIDTH,   // visible columns
  parameter int HEIGHT = mfld_pkg::DEF_HEIGHT   // visible rows
) (
  input  logic       clk,
  input  logic       rst,
  mfld_cmd_if.sink   cmd,
  mfld_rsp_if.source rsp
);

  // front: decode and queue the command words
  mfld_pkg::cmd_t   q_cmd;
  mfld_pkg::q_ctl_t qctl;
  logic             q_valid;
  logic             pop;

  assign qctl.valid = q_valid;

  mfld_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // back: frame store and walkers; one result word per command
  mfld_back #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .qin   (qctl),
    .q_cmd (q_cmd),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// ===== rtl/core/mfld_checker.sv =====
// ----------------------------------------------------------------------------
// mfld_checker: port-level checks of the drawer
// Responses against accepted commands, output hold, quiet after reset, in-flight bound.
// ----------------------------------------------------------------------------
module mfld_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_data
);

  logic [2:0] outstanding;
  logic       acc_in, acc_out;

  assign acc_in  = cmd_valid && cmd_ready;
  assign acc_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) outstanding <= '0;
    else     outstanding <= outstanding + 3'(acc_in) - 3'(acc_out);
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 3'd0)
    else $error("response without command");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd4)
    else $error("too many commands in flight");

endmodule

bind mono_framebuffer_line_arc_drawer mfld_checker u_mfld_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.read_data)
);
